FILE: rtl/core/assert_macros.svh
// Assertion helpers used by packet_rule_filter.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

FILE: rtl/core/prf_pkg.sv
// ---------------------------------------------------------------------------
// prf_pkg
// Shared types and constants of the packet rule filter.
// ---------------------------------------------------------------------------
`default_nettype none
package prf_pkg;
    localparam int RULES = 16;
    localparam int IDX_W = $clog2(RULES);
    localparam int CNT_W = $clog2(RULES + 1);

    localparam logic [1:0] KIND_CLEAR    = 2'd0;
    localparam logic [1:0] KIND_APPEND   = 2'd1;
    localparam logic [1:0] KIND_CLASSIFY = 2'd2;

    localparam logic [7:0] IPP_ICMP = 8'd1;
    localparam logic [7:0] IPP_TCP  = 8'd6;
    localparam logic [7:0] IPP_UDP  = 8'd17;

    localparam logic [1:0] RP_TCP  = 2'd0;
    localparam logic [1:0] RP_UDP  = 2'd1;
    localparam logic [1:0] RP_ICMP = 2'd2;

    localparam logic [3:0] CAUSE_NONE  = 4'd0;
    localparam logic [3:0] CAUSE_TCP   = 4'd1;
    localparam logic [3:0] CAUSE_UDP   = 4'd2;
    localparam logic [3:0] CAUSE_ICMP  = 4'd3;
    localparam logic [3:0] CAUSE_SIP   = 4'd4;
    localparam logic [3:0] CAUSE_DIP   = 4'd5;
    localparam logic [3:0] CAUSE_SPORT = 4'd6;
    localparam logic [3:0] CAUSE_DPORT = 4'd7;
    localparam logic [3:0] CAUSE_TIME  = 4'd8;
    localparam logic [3:0] CAUSE_DEV   = 4'd9;
    localparam int NCHK = 9;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  proto_code;
        logic [7:0]  dev_id;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] time_start;
        logic [31:0] time_end;
    } t_in;

    typedef struct packed {
        logic       drop;
        logic [3:0] cause;
        logic [3:0] rule_index;
        logic       load_ok;
    } t_out;

    // One stored rule.
    typedef struct packed {
        logic [1:0]  proto;
        logic [7:0]  dev;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] tstart;
        logic [31:0] tend;
    } t_rule;

    // Packet fields broadcast to every cell.
    typedef struct packed {
        logic [7:0]  proto;
        logic [7:0]  dev;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] now;
    } t_pkt;

    // Per-check first-hit state passed along the chain.
    typedef struct packed {
        logic [NCHK-1:0]             hit;
        logic [NCHK-1:0][IDX_W-1:0]  idx;
    } t_hits;
endpackage
`default_nettype wire

FILE: rtl/core/packet_rule_filter.sv
// Packet rule filter. Each transaction clears the rule table, appends one
// rule, or classifies one packet (other kinds leave the table alone);
// every transaction yields one result. The packet is registered, then its
// hits from the chain of rule cells (one cell per rule, each merging into
// the first-hit record from its neighbor) are encoded into the result
// register. The next transaction is accepted in the cycle after the
// previous result is registered; while a result waits at the output, the
// following transaction stays in the item register until the result is
// taken. No clearing pass is needed after reset.
`default_nettype none
`include "assert_macros.svh"
module packet_rule_filter (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire prf_pkg::t_in   i_data,
    output logic                o_valid,
    input  wire logic           i_stall,
    output prf_pkg::t_out       o_data
);
    import prf_pkg::*;

    logic               r_busy;
    t_in                r_item;
    t_in                n_item;
    logic [CNT_W-1:0]   r_count;
    logic               r_valid;
    t_out               r_out;
    logic               w_take;
    logic               w_out_free;
    t_pkt               w_pkt;
    t_hits              w_chain [RULES+1];
    logic               w_wr;
    t_out               n_out;

    assign w_out_free = !r_valid || !i_stall;
    assign o_stall    = r_busy;
    assign w_take     = i_valid && !r_busy;

    assign w_pkt = '{proto: r_item.proto_code, dev: r_item.dev_id, sip: r_item.src_ip,
                     dip: r_item.dst_ip, sport: r_item.sport,
                     dport: r_item.dport, now: r_item.time_start};

    assign w_wr = w_take && i_data.kind == KIND_APPEND && i_data.proto_code <= 8'd3
                  && r_count < CNT_W'(RULES);

    // Chain of rule cells.
    assign w_chain[0] = '0;
    for (genvar g = 0; g < RULES; g++) begin : g_cell
        prf_cell u_cell (
            .i_clk    (i_clk),
            .i_wr     (w_wr && r_count == CNT_W'(g)),
            .i_rule   ('{proto: i_data.proto_code[1:0], dev: i_data.dev_id,
                         sip: i_data.src_ip, dip: i_data.dst_ip,
                         sport: i_data.sport, dport: i_data.dport,
                         tstart: i_data.time_start, tend: i_data.time_end}),
            .i_active (CNT_W'(g) < r_count),
            .i_my_idx (IDX_W'(g)),
            .i_pkt    (w_pkt),
            .i_hits   (w_chain[g]),
            .o_hits   (w_chain[g+1])
        );
    end

    // Result encoding: first check in priority order that hit.
    always_comb begin
        n_out = '0;
        case (r_item.kind)
            KIND_CLEAR, KIND_APPEND: n_out.load_ok = r_item.time_end[0];
            KIND_CLASSIFY: begin
                for (int c = NCHK - 1; c >= 0; c--) begin
                    if (w_chain[RULES].hit[c]) begin
                        n_out.drop       = 1'b1;
                        n_out.cause      = 4'(c + 1);
                        n_out.rule_index = 4'(w_chain[RULES].idx[c]);
                    end
                end
            end
            default: n_out = '0;
        endcase
    end

    // Control: hold an item until the output is free, then publish its result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            if (r_busy && w_out_free) begin
                r_valid <= 1'b1;
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
            if (w_take) begin
                r_busy <= 1'b1;
                if (i_data.kind == KIND_CLEAR) begin
                    r_count <= '0;
                end else if (w_wr) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (r_busy && w_out_free) begin
                r_busy  <= 1'b0;
            end
        end
    end

    // For load items, time_end bit 0 carries load success.
    always_comb begin
        n_item = i_data;
        if (i_data.kind == KIND_CLEAR || i_data.kind == KIND_APPEND) begin
            n_item.time_end[0] = i_data.kind == KIND_CLEAR || w_wr;
        end
    end

    // Item and result registers.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= n_item;
        end
        if (r_busy && w_out_free) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

    `ASSERT_IMPLIES(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(RULES))
    `ASSERT_IMPLIES(a_no_take_busy, i_clk, i_rst_n, r_busy, !w_take)
    `ASSERT_NEXT(a_busy_to_out, i_clk, i_rst_n, r_busy && w_out_free, r_valid && !r_busy)
endmodule
`default_nettype wire

FILE: rtl/core/prf_cell.sv
// ---------------------------------------------------------------------------
// prf_cell
// Holds one rule, compares it with the packet and merges its hits into the
// first-hit record handed along the chain.
// ---------------------------------------------------------------------------
`default_nettype none
module prf_cell (
    input  wire logic                  i_clk,
    input  wire logic                  i_wr,
    input  wire prf_pkg::t_rule        i_rule,
    input  wire logic                  i_active,
    input  wire logic [prf_pkg::IDX_W-1:0] i_my_idx,
    input  wire prf_pkg::t_pkt         i_pkt,
    input  wire prf_pkg::t_hits        i_hits,
    output prf_pkg::t_hits             o_hits
);
    import prf_pkg::*;

    t_rule r_rule;
    logic [NCHK-1:0] w_hit;

    // Rule storage, written on append.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_rule <= i_rule;
        end
    end

    // The nine compares for this rule.
    always_comb begin
        w_hit[0] = i_pkt.proto == IPP_TCP && r_rule.proto == RP_TCP;
        w_hit[1] = i_pkt.proto == IPP_UDP && r_rule.proto == RP_UDP;
        w_hit[2] = i_pkt.proto == IPP_ICMP && r_rule.proto == RP_ICMP;
        w_hit[3] = r_rule.sip != '0 && r_rule.sip == i_pkt.sip;
        w_hit[4] = r_rule.dip != '0 && r_rule.dip == i_pkt.dip;
        w_hit[5] = i_pkt.proto == IPP_TCP && r_rule.sport != '0 &&
                   r_rule.sport == i_pkt.sport;
        w_hit[6] = i_pkt.proto == IPP_TCP && r_rule.dport != '0 &&
                   r_rule.dport == i_pkt.dport;
        w_hit[7] = r_rule.tstart <= i_pkt.now && i_pkt.now <= r_rule.tend;
        w_hit[8] = r_rule.dev != '0 && r_rule.dev == i_pkt.dev;
    end

    // An earlier rule keeps its claim on each check.
    always_comb begin
        o_hits = i_hits;
        for (int c = 0; c < NCHK; c++) begin
            if (!i_hits.hit[c] && i_active && w_hit[c]) begin
                o_hits.hit[c] = 1'b1;
                o_hits.idx[c] = i_my_idx;
            end
        end
    end
endmodule
`default_nettype wire

FILE: bench/packet_rule_filter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet rule filter scoreboard
// Watches both channels of the packet rule filter, keeps its own copy of the
// rule table, works out the verdict of every accepted input transaction and
// compares each accepted output transaction against the oldest expectation.
// ----------------------------------------------------------------------------
module packet_rule_filter_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  prf_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  prf_pkg::t_out i_out_data,
    output int            o_errors,
    output int            o_pending
);
    import prf_pkg::*;

    t_rule      table_q [RULES];
    int         rule_total;
    t_out       verdict_q [$];

    assign o_pending = verdict_q.size();

    // Work out the verdict of one packet against the rules held.
    function automatic t_out classify_packet(t_in pkt);
        t_out   res;
        logic   hit;
        res = '0;
        for (int chk = 1; chk <= NCHK; chk++) begin
            for (int i = 0; i < rule_total; i++) begin
                t_rule r;
                r = table_q[i];
                case (chk)
                    CAUSE_TCP:   hit = pkt.proto_code == IPP_TCP && r.proto == RP_TCP;
                    CAUSE_UDP:   hit = pkt.proto_code == IPP_UDP && r.proto == RP_UDP;
                    CAUSE_ICMP:  hit = pkt.proto_code == IPP_ICMP && r.proto == RP_ICMP;
                    CAUSE_SIP:   hit = r.sip != 0 && r.sip == pkt.src_ip;
                    CAUSE_DIP:   hit = r.dip != 0 && r.dip == pkt.dst_ip;
                    CAUSE_SPORT: hit = pkt.proto_code == IPP_TCP && r.sport != 0 &&
                                       r.sport == pkt.sport;
                    CAUSE_DPORT: hit = pkt.proto_code == IPP_TCP && r.dport != 0 &&
                                       r.dport == pkt.dport;
                    CAUSE_TIME:  hit = r.tstart <= pkt.time_start &&
                                       pkt.time_start <= r.tend;
                    default:     hit = r.dev != 0 && r.dev == pkt.dev_id;
                endcase
                if (hit) begin
                    res.drop = 1'b1;
                    res.cause = 4'(chk);
                    res.rule_index = 4'(i);
                    return res;
                end
            end
        end
        return res;
    endfunction

    // Apply one input transaction to the table and queue its verdict.
    function automatic void apply_item(t_in item);
        t_out res;
        res = '0;
        case (item.kind)
            KIND_CLEAR: begin
                rule_total = 0;
                res.load_ok = 1'b1;
            end
            KIND_APPEND: begin
                if (item.proto_code <= 3 && rule_total < RULES) begin
                    table_q[rule_total] = '{item.proto_code[1:0], item.dev_id, item.src_ip,
                        item.dst_ip, item.sport, item.dport, item.time_start,
                        item.time_end};
                    rule_total++;
                    res.load_ok = 1'b1;
                end
            end
            KIND_CLASSIFY: res = classify_packet(item);
            default: ;
        endcase
        verdict_q.push_back(res);
    endfunction

    // Sample both channels at each rising edge.
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            rule_total = 0;
            verdict_q.delete();
            o_errors = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                apply_item(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) begin
                        $display("ERROR: unexpected result %p", i_out_data);
                    end
                end else begin
                    want = verdict_q.pop_front();
                    if (want.drop !== i_out_data.drop || want.cause !== i_out_data.cause ||
                        want.rule_index !== i_out_data.rule_index ||
                        want.load_ok !== i_out_data.load_ok) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("ERROR: expected %p, got %p", want, i_out_data);
                        end
                    end
                end
            end
        end
    end
endmodule

FILE: bench/packet_rule_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet rule filter testbench
// Loads rule tables and classifies packets against them: a directed pass over
// every check and corner case, then random rule sets followed by packets that
// are built to hit or miss those rules. Both sides idle at random.
// ----------------------------------------------------------------------------
module packet_rule_filter_test;
    import prf_pkg::*;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_stall;
    t_in   i_data = '0;
    logic  o_valid;
    logic  i_stall = 1'b1;
    t_out  o_data;
    int    fail_count;
    int    pending;
    int    cycle_count = 0;
    bit    hold_off = 1'b0;
    bit    sending_done = 1'b0;

    // Rules of the current random table, used to aim packets at them.
    t_in   loaded [$];

    always #6 i_clk = ~i_clk;

    packet_rule_filter DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    packet_rule_filter_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_in_data(i_data), .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_out_data(o_data), .o_errors(fail_count), .o_pending(pending)
    );

    // Short gaps mostly, a long one now and then.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one transaction and hold it until accepted. Valid stays high into
    // the next transaction when there is no gap.
    task automatic send_item(t_in item);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= item;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic t_in make_rule(logic [7:0] proto, logic [7:0] dev,
                                      logic [31:0] sip, logic [31:0] dip,
                                      logic [15:0] sp, logic [15:0] dp,
                                      logic [31:0] ts, logic [31:0] te);
        return '{KIND_APPEND, proto, dev, sip, dip, sp, dp, ts, te};
    endfunction

    function automatic t_in make_packet(logic [7:0] proto, logic [7:0] dev,
                                        logic [31:0] sip, logic [31:0] dip,
                                        logic [15:0] sp, logic [15:0] dp,
                                        logic [31:0] now, logic [31:0] junk);
        return '{KIND_CLASSIFY, proto, dev, sip, dip, sp, dp, now, junk};
    endfunction

    // A random rule: most fields absent so packets can pass earlier checks.
    function automatic t_in random_rule();
        t_in r;
        r = make_rule(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3) == 0 ?
            $urandom : 0), $urandom_range(0, 2) == 0 ? $urandom : 0,
            $urandom_range(0, 2) == 0 ? $urandom : 0,
            $urandom_range(0, 2) == 0 ? 16'($urandom) : 16'h0,
            $urandom_range(0, 2) == 0 ? 16'($urandom) : 16'h0, 0, 0);
        if ($urandom_range(0, 2) == 0) begin
            r.time_start = $urandom;
            r.time_end = r.time_start + $urandom_range(0, 100000);
        end else begin
            r.time_start = 32'hFFFFFFFF;
            r.time_end = 32'h0;
        end
        if ($urandom_range(0, 19) == 0) r.proto_code = 8'($urandom);
        return r;
    endfunction

    // A random packet, often borrowing fields from a loaded rule.
    function automatic t_in random_packet();
        t_in p;
        t_in r;
        int pr;
        p = make_packet(8'($urandom), 8'($urandom), $urandom, $urandom, 16'($urandom),
                        16'($urandom), $urandom, $urandom);
        pr = $urandom_range(0, 9);
        if (pr < 3) p.proto_code = IPP_TCP;
        else if (pr < 5) p.proto_code = IPP_UDP;
        else if (pr < 6) p.proto_code = IPP_ICMP;
        if (p.proto_code == IPP_UDP && $urandom_range(0, 2) == 0) p.dport = 16'd53;
        if (loaded.size() > 0) begin
            r = loaded[$urandom_range(0, loaded.size() - 1)];
            case ($urandom_range(0, 6))
                0: p.src_ip = r.src_ip;
                1: p.dst_ip = r.dst_ip;
                2: p.sport = r.sport;
                3: p.dport = r.dport;
                4: p.time_start = r.time_start + $urandom_range(0, 2) - 1;
                5: p.time_start = r.time_end + $urandom_range(0, 2) - 1;
                default: p.dev_id = r.dev_id;
            endcase
        end
        return p;
    endfunction

    // Output side: random stalls, plus one long forced hold-off.
    initial begin
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        @(posedge i_clk);
        while (1) begin
            if (hold_off && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (60) @(posedge i_clk);
            end else if (sending_done || $urandom_range(0, 3) != 0) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                gap = gap_length() + 1;
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // Run-length guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 1000000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus and verdict.
    initial begin
        t_in item;
        int sent;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, each check, priority and edge values.
        send_item(make_packet(IPP_TCP, 8'hFF, '1, '1, '1, '1, '1, '1));
        send_item('{2'd3, '1, '1, '1, '1, '1, '1, '1, '1});
        send_item(make_rule(8'd4, 0, 0, 0, 0, 0, '1, 0));
        send_item(make_rule(8'hFF, 0, 0, 0, 0, 0, '1, 0));
        send_item(make_rule(8'd3, 8'hFF, 32'hFFFFFFFF, 32'h0A000001, 16'hFFFF, 16'd80,
                            32'd100, 32'd200));
        send_item(make_rule({6'd0, RP_UDP}, 0, 0, 0, 0, 0, '1, 0));
        send_item(make_packet(IPP_UDP, 0, 0, 0, 0, 16'd53, 0, 0));
        send_item(make_packet(IPP_UDP, 0, 0, 0, 0, 16'd54, 0, 0));
        send_item(make_packet(8'd0, 0, 32'hFFFFFFFF, 0, 0, 0, 0, 0));
        send_item(make_packet(8'd0, 0, 0, 32'h0A000001, 0, 0, 0, 0));
        send_item(make_packet(IPP_TCP, 0, 0, 0, 16'hFFFF, 0, 0, 0));
        send_item(make_packet(IPP_UDP, 0, 0, 0, 16'hFFFF, 16'd80, 0, 0));
        send_item(make_packet(IPP_TCP, 0, 0, 0, 0, 16'd80, 0, 0));
        send_item(make_packet(8'd0, 0, 0, 0, 0, 0, 32'd100, 0));
        send_item(make_packet(8'd0, 0, 0, 0, 0, 0, 32'd201, 0));
        send_item(make_packet(8'd0, 8'hFF, 0, 0, 0, 0, 32'd99, 0));
        send_item(make_rule({6'd0, RP_TCP}, 0, 0, 0, 0, 0, '1, 0));
        send_item(make_rule({6'd0, RP_ICMP}, 0, 0, 0, 0, 0, '1, 0));
        send_item(make_packet(IPP_TCP, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_packet(IPP_ICMP, 0, 0, 0, 0, 0, 0, 0));
        // Fill the table, then try one more append.
        for (int i = 0; i < RULES - 4 + 1; i++) begin
            send_item(make_rule(8'd3, 8'(i + 1), 0, 0, 0, 0, '1, 0));
        end
        send_item(make_packet(8'd0, 8'(RULES - 4), 0, 0, 0, 0, 0, 0));
        send_item('{KIND_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0});
        send_item(make_packet(IPP_TCP, 0, 0, 0, 0, 0, 0, 0));

        // Random: rule sets followed by aimed packets, a few odd items.
        sent = 0;
        while (sent < 1350) begin
            loaded.delete();
            send_item('{KIND_CLEAR, 8'($urandom), 8'($urandom), $urandom, $urandom,
                        16'($urandom), 16'($urandom), $urandom, $urandom});
            repeat ($urandom_range(1, RULES + 1)) begin
                item = random_rule();
                if (item.proto_code <= 3) loaded.push_back(item);
                send_item(item);
                sent++;
            end
            repeat ($urandom_range(5, 30)) begin
                item = random_packet();
                if ($urandom_range(0, 39) == 0) item.kind = 2'd3;
                if (sent >= 300) begin
                    hold_off = 1'b1;
                end
                send_item(item);
                sent++;
            end
        end
        i_valid <= 1'b0;

        sending_done = 1'b1;
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

FILE: packet_rule_filter.f
+incdir+rtl/core
rtl/core/prf_pkg.sv
rtl/core/prf_cell.sv
rtl/core/packet_rule_filter.sv
bench/packet_rule_filter_checker.sv
bench/packet_rule_filter_test.sv
